// ----- design/necir_pkg.sv -----
// Shared types and constants for the NEC IR command decoder.
// No dependencies; imported by every module of the block except necir_queue.
`default_nettype none

package necir_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int KEY_W      = 8;
  localparam int THRESH_W   = 15;
  localparam int NUM_KEYS   = 6;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKWARD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd6;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_FORWARD  = 3'd1,
    ACT_BACKWARD = 3'd2,
    ACT_LEFT     = 3'd3,
    ACT_RIGHT    = 3'd4,
    ACT_STOP     = 3'd5,
    ACT_RESET    = 3'd6,
    ACT_UNKNOWN  = 3'd7
  } action_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- design/necir_front.sv -----
// Symbol front end: bit slicing against the threshold, code assembly,
// frame-end detection. Depends on necir_pkg.
`default_nettype none

module necir_front #(
  parameter int DATA_BITS  = 32,
  parameter int TICK_WIDTH = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire necir_pkg::cfg_wr_t    cfg_wr,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TICK_WIDTH-1:0] in_space_ticks,
  input  wire logic                  in_frame_end,
  input  wire logic                  q_full,
  output logic                       push,
  output logic                       push_whole,
  output logic [DATA_BITS-1:0]       push_code
);
  import necir_pkg::*;

  localparam int POS_W = $clog2(DATA_BITS + 2);
  localparam int CMP_W = (TICK_WIDTH > THRESH_W) ? TICK_WIDTH : THRESH_W;
  localparam logic [POS_W-1:0] FRAME_SYMBOLS = POS_W'(DATA_BITS + 1);
  localparam logic [POS_W-1:0] LAST_BIT_POS  = POS_W'(DATA_BITS);

  logic [THRESH_W-1:0]  thresh_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [DATA_BITS-1:0] code_r, code_nxt;
  logic                 accept;
  logic                 bit_val;
  logic                 in_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign bit_val = CMP_W'(in_space_ticks) > CMP_W'(thresh_r);
  assign in_data = (pos_r != '0) && (pos_r <= LAST_BIT_POS);

  always_comb begin
    code_nxt = code_r;
    if (in_data) begin
      code_nxt = {code_r[DATA_BITS-2:0], bit_val};
    end
    pos_nxt = (pos_r < FRAME_SYMBOLS) ? pos_r + POS_W'(1) : pos_r;
  end

  assign push       = accept && in_frame_end;
  assign push_whole = (pos_nxt >= FRAME_SYMBOLS);
  // short frames carry a zero code
  assign push_code  = push_whole ? code_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      pos_r    <= '0;
      code_r   <= '0;
    end else begin
      if (cfg_wr.en && cfg_wr.idx == REG_THRESH) begin
        thresh_r <= cfg_wr.data[THRESH_W-1:0];
      end
      if (accept) begin
        if (in_frame_end) begin
          pos_r  <= '0;
          code_r <= '0;
        end else begin
          pos_r  <= pos_nxt;
          code_r <= code_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/necir_queue.sv -----
// Two-entry frame queue between front end and command matcher.
// No dependencies.
`default_nettype none

module necir_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/necir_back.sv -----
// Command matcher: key registers, priority match of the command byte,
// output register. Depends on necir_pkg.
`default_nettype none

module necir_back #(
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire necir_pkg::cfg_wr_t   cfg_wr,
  input  wire logic                 q_valid,
  input  wire logic                 q_whole,
  input  wire logic [DATA_BITS-1:0] q_code,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output necir_pkg::action_t        out_action,
  output logic [DATA_BITS-1:0]      out_frame_code
);
  import necir_pkg::*;

  localparam int EXT_W = (DATA_BITS < 16) ? 16 : DATA_BITS;

  logic [KEY_W-1:0]     key_r [NUM_KEYS];
  logic                 out_valid_r;
  action_t              out_action_r, act;
  logic [DATA_BITS-1:0] out_code_r;
  logic [EXT_W-1:0]     code_ext;
  logic [KEY_W-1:0]     cmd;

  assign code_ext = EXT_W'(q_code);
  assign cmd      = code_ext[15:8];

  always_comb begin
    if (!q_whole)               act = ACT_NONE;
    else if (cmd == key_r[0])   act = ACT_FORWARD;
    else if (cmd == key_r[1])   act = ACT_BACKWARD;
    else if (cmd == key_r[2])   act = ACT_LEFT;
    else if (cmd == key_r[3])   act = ACT_RIGHT;
    else if (cmd == key_r[4])   act = ACT_STOP;
    else if (cmd == key_r[5])   act = ACT_RESET;
    else                        act = ACT_UNKNOWN;
  end

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.idx)
        REG_FORWARD:  key_r[0] <= cfg_wr.data[KEY_W-1:0];
        REG_BACKWARD: key_r[1] <= cfg_wr.data[KEY_W-1:0];
        REG_LEFT:     key_r[2] <= cfg_wr.data[KEY_W-1:0];
        REG_RIGHT:    key_r[3] <= cfg_wr.data[KEY_W-1:0];
        REG_STOP:     key_r[4] <= cfg_wr.data[KEY_W-1:0];
        REG_RESET:    key_r[5] <= cfg_wr.data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_action_r <= act;
      out_code_r   <= q_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_frame_code = out_code_r;

endmodule

`default_nettype wire

// ----- design/nec_ir_command_decoder.sv -----
// NEC IR command decoder, top level. Depends on necir_pkg, necir_front,
// necir_queue and necir_back.
// Throughput: one symbol per cycle unless the queue is full; the front end takes
// a symbol while results wait in the two-entry queue and the output register.
// A frame's result enters the queue at the edge that takes its last symbol,
// then moves to the output register when the matcher pops it.
// Reset (sync, active low): position and code cleared, queue empty,
// keys 0, threshold 1000.
`default_nettype none

module nec_ir_command_decoder #(
  parameter int DATA_BITS  = 32,
  parameter int TICK_WIDTH = 15
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [necir_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [TICK_WIDTH-1:0]            in_space_ticks,
  input  wire logic                             in_frame_end,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output necir_pkg::action_t                    out_action,
  output logic [DATA_BITS-1:0]                  out_frame_code
);
  import necir_pkg::*;

  cfg_wr_t              cfg_wr;
  logic                 push, push_whole, q_full, q_pop, q_valid;
  logic [DATA_BITS-1:0] push_code;
  logic [DATA_BITS:0]   q_data;

  assign cfg_wr = '{en: cfg_we, idx: cfg_index, data: cfg_wdata};

  necir_front #(
    .DATA_BITS (DATA_BITS),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_space_ticks(in_space_ticks),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .push          (push),
    .push_whole    (push_whole),
    .push_code     (push_code)
  );

  necir_queue #(
    .WIDTH(DATA_BITS + 1)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_whole, push_code}),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_data)
  );

  necir_back #(
    .DATA_BITS(DATA_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .q_valid       (q_valid),
    .q_whole       (q_data[DATA_BITS]),
    .q_code        (q_data[DATA_BITS-1:0]),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_frame_code(out_frame_code)
  );

  // a short frame never carries a code
  a_none_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |-> out_frame_code == '0)
    else $error("short-frame result with nonzero code");

  // a frame end taken in is queued
  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_frame_end |=> q_valid)
    else $error("frame end accepted but queue empty");

  // queued frames leave only through the matcher
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_pop |=> q_valid)
    else $error("queued frame lost");

endmodule

`default_nettype wire

// ----- tb/sv/necir_frame_checker.sv -----
// Scoreboard for the NEC IR command decoder: tracks key/threshold writes,
// predicts one result per frame end and compares the results channel.
// Depends on necir_pkg.
`timescale 1ns / 100ps

module necir_frame_checker #(
  parameter int DATA_BITS  = 32,
  parameter int TICK_WIDTH = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [necir_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [TICK_WIDTH-1:0]            in_space_ticks,
  input  logic                             in_frame_end,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  necir_pkg::action_t               out_action,
  input  logic [DATA_BITS-1:0]             out_frame_code,
  output int                               fail_count,
  output int                               results_checked,
  output int                               pending_results
);
  import necir_pkg::*;

  typedef struct {
    action_t              action;
    logic [DATA_BITS-1:0] code;
  } frame_result_t;

  frame_result_t         expected_frames[$];
  logic [5:0]            sym_pos;
  logic [DATA_BITS-1:0]  code_acc;
  logic [KEY_W-1:0]      key_val [NUM_KEYS];
  logic [THRESH_W-1:0]   thresh;

  // first matching key wins, in register order forward .. reset
  function automatic action_t command_action(input logic [KEY_W-1:0] cmd);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (cmd == key_val[k]) return action_t'(ACT_FORWARD + k);
    end
    return ACT_UNKNOWN;
  endfunction

  task automatic decode_symbol(input logic [TICK_WIDTH-1:0] ticks, input logic last);
    frame_result_t res;
    if (sym_pos >= 1 && sym_pos <= DATA_BITS) begin
      code_acc = {code_acc[DATA_BITS-2:0], (ticks > thresh)};
    end
    if (sym_pos < DATA_BITS + 1) sym_pos = sym_pos + 6'd1;
    if (last) begin
      if (sym_pos == DATA_BITS + 1) begin
        res.action = command_action(code_acc[15:8]);
        res.code   = code_acc;
      end else begin
        res.action = ACT_NONE;
        res.code   = '0;
      end
      expected_frames.push_back(res);
      sym_pos  = '0;
      code_acc = '0;
    end
  endtask

  initial begin
    fail_count      = 0;
    results_checked = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      expected_frames.delete();
      sym_pos  = '0;
      code_acc = '0;
      thresh   = THRESH_RESET;
      for (int k = 0; k < NUM_KEYS; k++) key_val[k] = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result transaction: action %0d, frame_code %h",
                 out_action, out_frame_code);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          results_checked++;
          if (out_action !== want.action) begin
            $error("action mismatch: expected %0d, actual %0d", want.action, out_action);
            fail_count++;
          end
          if (out_frame_code !== want.code) begin
            $error("frame_code mismatch: expected %h, actual %h", want.code, out_frame_code);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index) inside
          REG_FORWARD, REG_BACKWARD, REG_LEFT, REG_RIGHT, REG_STOP, REG_RESET: begin
            key_val[cfg_index] = cfg_wdata[KEY_W-1:0];
          end
          REG_THRESH: thresh = cfg_wdata[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_symbol(in_space_ticks, in_frame_end);
    end
    pending_results = expected_frames.size();
  end

endmodule

// ----- tb/sv/tb_nec_ir_command_decoder.sv -----
// Top-level bench for nec_ir_command_decoder: clock, reset, symbol frames,
// key/threshold programming and random back-pressure.
// Depends on necir_pkg, the decoder RTL and necir_frame_checker.
`timescale 1ns / 100ps

module tb_nec_ir_command_decoder;
  import necir_pkg::*;

  localparam int DATA_BITS   = 32;
  localparam int TICK_WIDTH  = 15;
  localparam int TICK_MAX    = (1 << TICK_WIDTH) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic [TICK_WIDTH-1:0] in_space_ticks = '0;
  logic                  in_frame_end   = 1'b0;
  logic                  out_stall      = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  action_t               out_action;
  logic [DATA_BITS-1:0]  out_frame_code;

  int fail_count;
  int results_checked;
  int pending_results;

  int         cycle_count   = 0;
  int         symbols_sent  = 0;
  int         frames_sent   = 0;
  int         thresh_shadow = THRESH_RESET;
  logic [7:0] key_shadow [NUM_KEYS];
  bit         no_idle       = 1'b0;
  bit         hold_req      = 1'b0;
  bit         holding       = 1'b0;

  nec_ir_command_decoder #(
    .DATA_BITS  (DATA_BITS),
    .TICK_WIDTH (TICK_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_space_ticks (in_space_ticks),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_frame_code (out_frame_code)
  );

  necir_frame_checker #(
    .DATA_BITS  (DATA_BITS),
    .TICK_WIDTH (TICK_WIDTH)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_space_ticks  (in_space_ticks),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_frame_code  (out_frame_code),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .pending_results (pending_results)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(50, 15);
  endfunction

  // space for a wanted bit value; lands on the threshold edges now and then
  function automatic logic [TICK_WIDTH-1:0] pick_ticks(input logic want_one);
    int r;
    r = $urandom_range(9, 0);
    if (want_one) begin
      if (thresh_shadow >= TICK_MAX) return TICK_WIDTH'(TICK_MAX);
      if (r == 0) return TICK_WIDTH'(thresh_shadow + 1);
      return TICK_WIDTH'($urandom_range(TICK_MAX, thresh_shadow + 1));
    end
    if (r == 0) return TICK_WIDTH'(thresh_shadow);
    return TICK_WIDTH'($urandom_range(thresh_shadow, 0));
  endfunction

  // random code whose command byte usually hits one of the keys
  function automatic logic [DATA_BITS-1:0] pick_code();
    logic [DATA_BITS-1:0] code;
    code = $urandom;
    if ($urandom_range(9, 0) < 7) code[15:8] = key_shadow[$urandom_range(NUM_KEYS-1, 0)];
    return code;
  endfunction

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_symbol(input logic [TICK_WIDTH-1:0] ticks, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_space_ticks <= ticks;
    in_frame_end   <= last;
    do @(posedge clk); while (in_stall);
    symbols_sent++;
    @(negedge clk);
  endtask

  // leader, then data symbols carrying code MSB first, then any excess
  task automatic send_frame(input int len, input logic [DATA_BITS-1:0] code);
    for (int i = 0; i < len; i++) begin
      if (i >= 1 && i <= DATA_BITS) send_symbol(pick_ticks(code[DATA_BITS-i]), i == len - 1);
      else send_symbol(TICK_WIDTH'($urandom_range(TICK_MAX, 0)), i == len - 1);
    end
    frames_sent++;
  endtask

  task automatic run_random(input int count);
    int start;
    int r;
    start = symbols_sent;
    while (symbols_sent - start < count) begin
      r = $urandom_range(99, 0);
      if (r < 60) send_frame(DATA_BITS + 1, pick_code());
      else if (r < 74) send_frame($urandom_range(DATA_BITS, 2), pick_code());
      else if (r < 86) send_frame($urandom_range(DATA_BITS + 8, DATA_BITS + 2), pick_code());
      else if (r < 93) send_frame(1, '0);
      else send_frame($urandom_range(DATA_BITS + 12, 1), $urandom);
    end
  endtask

  // drain everything in flight so register writes land on an idle block
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic apply_settings();
    for (int k = 0; k < NUM_KEYS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(REG_FORWARD + k);
      // upper data bits are junk for key registers
      cfg_wdata <= CFG_DATA_W'(($urandom_range(127, 0) << KEY_W) | key_shadow[k]);
      @(negedge clk);
    end
    cfg_index <= REG_THRESH;
    cfg_wdata <= CFG_DATA_W'(thresh_shadow);
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom_range(TICK_MAX, 0));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int r;
    int len;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        r = $urandom_range(99, 0);
        if (r < 55) begin
          out_stall <= 1'b0;
          len = $urandom_range(10, 1);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          len = $urandom_range(3, 1);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(60, 20);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, pending_results);
    $display("nec_ir_command_decoder test failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) key_shadow[k] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: all keys 0, threshold 1000
    send_symbol(TICK_MAX, 1'b1);                 // leader only
    send_symbol(15'd0, 1'b0);                    // short frame around threshold
    send_symbol(15'd1001, 1'b0);
    send_symbol(15'd1000, 1'b0);
    send_symbol(TICK_MAX, 1'b1);
    send_frame(DATA_BITS + 1, 32'hA55A_00FF);    // command 0 hits every key
    finish_phase();

    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < NUM_KEYS; k++) key_shadow[k] = 8'($urandom_range(255, 0));
      if ($urandom_range(2, 0) == 0) begin
        key_shadow[$urandom_range(NUM_KEYS - 1, 1)] = key_shadow[REG_FORWARD];
      end
      case (p)
        0: thresh_shadow = THRESH_RESET;
        1: thresh_shadow = 0;
        2: begin
          thresh_shadow = TICK_MAX;              // every bit reads 0
          key_shadow[REG_STOP] = 8'h00;
        end
        3: begin
          thresh_shadow = 1;
          for (int k = 0; k < NUM_KEYS; k++) key_shadow[k] = 8'hFF;
        end
        default: thresh_shadow = $urandom_range(3000, 200);
      endcase
      apply_settings();
      no_idle = (p == 1);
      run_random((p == 2) ? 120 : 280);
      if (p == 3) begin
        // long receiver hold-off while frame ends keep coming
        in_valid <= 1'b0;
        hold_req = 1'b1;
        wait (holding);
        no_idle = 1'b1;
        repeat (16) send_frame(1, '0);
      end
      no_idle = 1'b0;
      finish_phase();
    end

    $display("Sent %0d symbols in %0d frames over 7 register settings, incl. threshold edges",
             symbols_sent, frames_sent);
    $display("and a long result hold-off; %0d results compared, %0d mismatches",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("nec_ir_command_decoder test passed");
    end else begin
      $display("nec_ir_command_decoder test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/necir_pkg.sv
design/necir_front.sv
design/necir_queue.sv
design/necir_back.sv
design/nec_ir_command_decoder.sv
tb/sv/necir_frame_checker.sv
tb/sv/tb_nec_ir_command_decoder.sv
